@@ rtl/cose_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_pkg: shared types and constants of the opcode subset execute core
// Beat structs, decoded-instruction layout, instruction class codes, and the
// instruction length and cycle tables.
// ----------------------------------------------------------------------------
package cose_pkg;

    // Default sizing
    localparam int MEM_ADDR_BITS = 12;
    localparam int QUEUE_DEPTH   = 2;

    // Architectural reset values
    localparam logic [7:0]  RST_A  = 8'h01;
    localparam logic [3:0]  RST_F  = 4'hB;    // Z N H C, low nibble is always zero
    localparam logic [15:0] RST_BC = 16'h0013;
    localparam logic [15:0] RST_HL = 16'h014D;
    localparam logic [15:0] RST_SP = 16'hFFFE;
    localparam logic [15:0] RST_PC = 16'h0100;

    // Flag bit positions inside the 4-bit flag register
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Instruction classes
    localparam logic [3:0] K_NOP       = 4'd0;
    localparam logic [3:0] K_LD_BC_IMM = 4'd1;
    localparam logic [3:0] K_ST_BC_A   = 4'd2;
    localparam logic [3:0] K_INC_BC    = 4'd3;
    localparam logic [3:0] K_DEC_BC    = 4'd4;
    localparam logic [3:0] K_INC_R8    = 4'd5;
    localparam logic [3:0] K_DEC_R8    = 4'd6;
    localparam logic [3:0] K_LD_R8     = 4'd7;
    localparam logic [3:0] K_ROT       = 4'd8;
    localparam logic [3:0] K_ST_SP     = 4'd9;
    localparam logic [3:0] K_ADD_HL    = 4'd10;
    localparam logic [3:0] K_LD_A_BC   = 4'd11;
    localparam logic [3:0] K_UNSUP     = 4'd12;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_a;
        logic [7:0]  out_flags;
        logic [15:0] out_bc;
        logic [15:0] out_hl;
        logic [15:0] out_sp;
        logic [15:0] out_pc;
        logic [4:0]  cycle_count;
        logic        unsupported;
    } t_result;

    // Decoded instruction handed from front to back
    typedef struct packed {
        logic [3:0]  kind;
        logic        sel_c;      // 8-bit ops: 1 selects C, 0 selects B
        logic        rot_right;  // rotate: 1 is RRCA, 0 is RLCA
        logic [15:0] imm16;
        logic [1:0]  len;        // PC advance
        logic [4:0]  cycles;
    } t_dec;

    typedef struct packed {
        logic clearing;          // memory clear pass still running
    } t_back_stat;

    function automatic logic [1:0] op_len(input logic [3:0] op);
        logic [1:0] v;
        case (op)
            4'h1, 4'h8:  v = 2'd3;
            4'h6, 4'hE:  v = 2'd2;
            default:     v = 2'd1;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] op_cycles(input logic [3:0] op);
        logic [4:0] v;
        case (op)
            4'h1:                             v = 5'd12;
            4'h8:                             v = 5'd20;
            4'h2, 4'h3, 4'h6, 4'h9, 4'hA,
            4'hB, 4'hE:                       v = 5'd8;
            default:                          v = 5'd4;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/cose_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_front: instruction intake and decode
// Takes input beats, classifies the opcode and pushes the decoded form into
// the queue toward the execute side.
// ----------------------------------------------------------------------------
module cose_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cose_pkg::t_item      i_item,
    input  cose_pkg::t_back_stat i_stat,
    input  logic                 i_q_full,
    output logic                 o_push,
    output cose_pkg::t_dec       o_dec
);

    logic r_busy_rst;   // holds off intake for the cycle after reset release

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_rst <= 1'b1;
        end else begin
            r_busy_rst <= 1'b0;
        end
    end

    assign o_ready = !i_q_full && !i_stat.clearing && !r_busy_rst;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_dec.sel_c     = i_item.opcode[3];
        o_dec.rot_right = i_item.opcode[3];
        o_dec.imm16     = {i_item.imm_high, i_item.imm_low};
        o_dec.len       = cose_pkg::op_len(i_item.opcode[3:0]);
        o_dec.cycles    = cose_pkg::op_cycles(i_item.opcode[3:0]);
        unique case (i_item.opcode) inside
            8'h00:        o_dec.kind = cose_pkg::K_NOP;
            8'h01:        o_dec.kind = cose_pkg::K_LD_BC_IMM;
            8'h02:        o_dec.kind = cose_pkg::K_ST_BC_A;
            8'h03:        o_dec.kind = cose_pkg::K_INC_BC;
            8'h0B:        o_dec.kind = cose_pkg::K_DEC_BC;
            8'h04, 8'h0C: o_dec.kind = cose_pkg::K_INC_R8;
            8'h05, 8'h0D: o_dec.kind = cose_pkg::K_DEC_R8;
            8'h06, 8'h0E: o_dec.kind = cose_pkg::K_LD_R8;
            8'h07, 8'h0F: o_dec.kind = cose_pkg::K_ROT;
            8'h08:        o_dec.kind = cose_pkg::K_ST_SP;
            8'h09:        o_dec.kind = cose_pkg::K_ADD_HL;
            8'h0A:        o_dec.kind = cose_pkg::K_LD_A_BC;
            default: begin
                o_dec.kind   = cose_pkg::K_UNSUP;
                o_dec.len    = 2'd1;
                o_dec.cycles = 5'd0;
            end
        endcase
    end

endmodule

@@ rtl/cose_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_queue: short queue of decoded instructions
// Circular buffer between decode and execute so each side stalls on its own.
// ----------------------------------------------------------------------------
module cose_queue #(
    parameter int DEPTH = cose_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cose_pkg::t_dec i_dec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cose_pkg::t_dec o_dec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    cose_pkg::t_dec   r_buf [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_dec   = r_buf[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_dec;
        end
    end

endmodule

@@ rtl/cose_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_back: execute side
// Holds the register file and the data memory, runs decoded instructions and
// drives the result register. Clears the memory after reset.
// ----------------------------------------------------------------------------
module cose_back #(
    parameter int MEM_ADDR_BITS = cose_pkg::MEM_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  cose_pkg::t_dec       i_q_dec,
    output logic                 o_q_pop,
    output cose_pkg::t_back_stat o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cose_pkg::t_result    o_result
);

    localparam int AW = MEM_ADDR_BITS;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;   // waiting on memory read data
    localparam logic [1:0] ST_STHI  = 2'd3;   // second byte of the SP store

    logic [7:0]  r_mem [MEM_DEPTH];
    logic [7:0]  r_rd_data;

    logic [1:0]  r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_st_addr, n_st_addr;
    logic [1:0]  r_pend_len, n_pend_len;
    logic [4:0]  r_pend_cyc, n_pend_cyc;

    logic [7:0]  r_a, n_a;
    logic [3:0]  r_f, n_f;
    logic [15:0] r_bc, n_bc;
    logic [15:0] r_hl, n_hl;
    logic [15:0] r_sp;
    logic [15:0] r_pc, n_pc;

    logic        r_out_valid, n_out_valid;
    cose_pkg::t_result r_res, n_res;

    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_re;

    logic        out_free;
    logic        pop;
    logic        done;
    logic [1:0]  done_len;
    logic [4:0]  done_cyc;
    logic        done_unsup;
    logic [7:0]  r8_src;
    logic [7:0]  r8_inc;
    logic [7:0]  r8_dec;
    logic [16:0] sum17;
    logic [12:0] half13;

    assign out_free = !r_out_valid || i_ready;
    assign pop      = (r_state == ST_RUN) && i_q_valid && out_free;
    assign o_q_pop  = pop;
    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    assign r8_src = i_q_dec.sel_c ? r_bc[7:0] : r_bc[15:8];
    assign r8_inc = r8_src + 8'd1;
    assign r8_dec = r8_src - 8'd1;
    assign sum17  = {1'b0, r_hl} + {1'b0, r_bc};
    assign half13 = {1'b0, r_hl[11:0]} + {1'b0, r_bc[11:0]};

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_st_addr  = r_st_addr;
        n_pend_len = r_pend_len;
        n_pend_cyc = r_pend_cyc;
        n_a        = r_a;
        n_f        = r_f;
        n_bc       = r_bc;
        n_hl       = r_hl;
        n_pc       = r_pc;
        mem_we     = 1'b0;
        mem_waddr  = r_bc[AW-1:0];
        mem_wdata  = r_a;
        mem_re     = 1'b0;
        done       = 1'b0;
        done_len   = i_q_dec.len;
        done_cyc   = i_q_dec.cycles;
        done_unsup = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = 8'd0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (pop) begin
                    done = 1'b1;
                    case (i_q_dec.kind)
                        cose_pkg::K_LD_BC_IMM: n_bc = i_q_dec.imm16;
                        cose_pkg::K_ST_BC_A: begin
                            mem_we = 1'b1;
                        end
                        cose_pkg::K_INC_BC: n_bc = r_bc + 16'd1;
                        cose_pkg::K_DEC_BC: n_bc = r_bc - 16'd1;
                        cose_pkg::K_INC_R8: begin
                            n_bc = i_q_dec.sel_c ? {r_bc[15:8], r8_inc} : {r8_inc, r_bc[7:0]};
                            n_f[cose_pkg::FLAG_Z] = (r8_inc == 8'd0);
                            n_f[cose_pkg::FLAG_N] = 1'b0;
                            n_f[cose_pkg::FLAG_H] = (r8_src[3:0] == 4'hF);
                        end
                        cose_pkg::K_DEC_R8: begin
                            n_bc = i_q_dec.sel_c ? {r_bc[15:8], r8_dec} : {r8_dec, r_bc[7:0]};
                            n_f[cose_pkg::FLAG_Z] = (r8_dec == 8'd0);
                            n_f[cose_pkg::FLAG_N] = 1'b1;
                            n_f[cose_pkg::FLAG_H] = (r8_src[3:0] == 4'h0);
                        end
                        cose_pkg::K_LD_R8: begin
                            n_bc = i_q_dec.sel_c ? {r_bc[15:8], i_q_dec.imm16[7:0]}
                                                 : {i_q_dec.imm16[7:0], r_bc[7:0]};
                        end
                        cose_pkg::K_ROT: begin
                            if (i_q_dec.rot_right) begin
                                n_a = {r_a[0], r_a[7:1]};
                                n_f = {3'b000, r_a[0]};
                            end else begin
                                n_a = {r_a[6:0], r_a[7]};
                                n_f = {3'b000, r_a[7]};
                            end
                        end
                        cose_pkg::K_ST_SP: begin
                            // low byte now, high byte at address + 1 from ST_STHI once the output is free
                            mem_we     = 1'b1;
                            mem_waddr  = i_q_dec.imm16[AW-1:0];
                            mem_wdata  = r_sp[7:0];
                            n_st_addr  = i_q_dec.imm16[AW-1:0] + 1'b1;
                            n_pend_len = i_q_dec.len;
                            n_pend_cyc = i_q_dec.cycles;
                            n_state    = ST_STHI;
                            done       = 1'b0;
                        end
                        cose_pkg::K_ADD_HL: begin
                            n_hl = sum17[15:0];
                            n_f[cose_pkg::FLAG_N] = 1'b0;
                            n_f[cose_pkg::FLAG_H] = half13[12];
                            n_f[cose_pkg::FLAG_C] = sum17[16];
                        end
                        cose_pkg::K_LD_A_BC: begin
                            mem_re     = 1'b1;
                            n_pend_len = i_q_dec.len;
                            n_pend_cyc = i_q_dec.cycles;
                            n_state    = ST_LOAD;
                            done       = 1'b0;
                        end
                        cose_pkg::K_UNSUP: done_unsup = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                done_len = r_pend_len;
                done_cyc = r_pend_cyc;
                if (out_free) begin
                    n_a     = r_rd_data;
                    done    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_STHI: begin
                done_len  = r_pend_len;
                done_cyc  = r_pend_cyc;
                mem_waddr = r_st_addr;
                mem_wdata = r_sp[15:8];
                if (out_free) begin
                    mem_we  = 1'b1;
                    done    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase

        if (done) begin
            n_pc = r_pc + {14'd0, done_len};
        end

        n_res.out_a       = n_a;
        n_res.out_flags   = {n_f, 4'h0};
        n_res.out_bc      = n_bc;
        n_res.out_hl      = n_hl;
        n_res.out_sp      = r_sp;
        n_res.out_pc      = n_pc;
        n_res.cycle_count = done_cyc;
        n_res.unsupported = done_unsup;

        n_out_valid = done ? 1'b1 : (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_a         <= cose_pkg::RST_A;
            r_f         <= cose_pkg::RST_F;
            r_bc        <= cose_pkg::RST_BC;
            r_hl        <= cose_pkg::RST_HL;
            r_sp        <= cose_pkg::RST_SP;
            r_pc        <= cose_pkg::RST_PC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_a         <= n_a;
            r_f         <= n_f;
            r_bc        <= n_bc;
            r_hl        <= n_hl;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_addr  <= n_st_addr;
        r_pend_len <= n_pend_len;
        r_pend_cyc <= n_pend_cyc;
        if (done) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[r_bc[AW-1:0]];
        end
    end

endmodule

@@ rtl/cpu_opcode_subset_execute_core.sv @@
`timescale 1ns / 1ps
// Flow: an accepted beat is registered in the queue, then in the result register;
//   LD A,(BC) and LD (u16),SP also pass ST_LOAD or ST_STHI for the memory port.
// Throughput: one beat per cycle for register ops while the result is not stalled;
//   LD A,(BC), LD (u16),SP add ST_LOAD/ST_STHI (registered read, single write port).
// Reset: synchronous, active low; registers load their power-on values, then the data
//   memory is cleared one byte per cycle, all 2^MEM_ADDR_BITS bytes, with o_ready low.
// ----------------------------------------------------------------------------
// cpu_opcode_subset_execute_core: top level of the opcode subset execute core
// Front decodes each instruction beat, a short queue decouples it from the
// execute side, which owns the register file, data memory and result register.
// ----------------------------------------------------------------------------
module cpu_opcode_subset_execute_core #(
    parameter int MEM_ADDR_BITS = cose_pkg::MEM_ADDR_BITS,  // 8..16
    parameter int QUEUE_DEPTH   = cose_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // instruction beats in
    input  logic              i_valid,
    output logic              o_ready,
    input  cose_pkg::t_item   i_item,
    // result beats out
    output logic              o_valid,
    input  logic              i_ready,
    output cose_pkg::t_result o_result
);

    // front -> queue
    logic                 push;
    cose_pkg::t_dec       push_dec;
    logic                 q_full;
    // queue -> back
    logic                 q_valid;
    cose_pkg::t_dec       q_dec;
    logic                 q_pop;
    // back -> front: intake is held off while the memory clear runs
    cose_pkg::t_back_stat back_stat;

    cose_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_stat   (back_stat),
        .i_q_full (q_full),
        .o_push   (push),
        .o_dec    (push_dec)
    );

    cose_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_dec   (push_dec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_dec   (q_dec)
    );

    // Executes in order; a result waits in the output register, and the
    // next instruction completes only when that register is free or being read.
    cose_back #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_dec   (q_dec),
        .o_q_pop   (q_pop),
        .o_stat    (back_stat),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

endmodule

@@ rtl/cose_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_checker: port-level checks for the opcode subset execute core
// Watches the top ports, checks intake is held off after reset, and flags
// result beats that break the handshake or the flag and cycle-count encoding.
// ----------------------------------------------------------------------------
module cose_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input cose_pkg::t_item   i_item,
    input logic              o_valid,
    input logic              i_ready,
    input cose_pkg::t_result o_result
);

    // stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result beat changed while stalled");

    // no intake right after reset: memory clear pass runs first
    a_rst_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("beat possible straight after reset");

    // unsupported opcodes report zero cycles
    a_unsup_cyc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.unsupported |-> o_result.cycle_count == 5'd0)
        else $error("unsupported result with nonzero cycle count");

    // supported results carry a table cycle count and a clean flag nibble
    a_res_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.unsupported |->
            (o_result.cycle_count == 5'd4 || o_result.cycle_count == 5'd8 ||
             o_result.cycle_count == 5'd12 || o_result.cycle_count == 5'd20) &&
            o_result.out_flags[3:0] == 4'h0)
        else $error("bad cycle count or flag low nibble");

endmodule

bind cpu_opcode_subset_execute_core cose_checker u_cose_checker (.*);
